@@ sv/ncm_pkg.sv @@
// Types, constants and helper functions for the narrow-phase collision manifold unit.
`timescale 1ns / 1ps

package ncm_pkg;

   localparam int CW   = 24;
   localparam int RW   = CW - 1;
   localparam int MW   = CW + 1;
   localparam int NF   = 14;
   localparam int NW   = 16;
   localparam int L2W  = 2 * MW;
   localparam int SQW  = MW;
   localparam int QW   = NF + 1;
   localparam int NUMW = MW + NF + 1;
   localparam int DSW  = MW + 2;
   localparam int PW   = NW + DSW;
   localparam int TW   = PW - NF + 2;

   localparam logic [1:0] OP_CC = 2'd0;
   localparam logic [1:0] OP_BB = 2'd1;
   localparam logic [1:0] OP_CB = 2'd2;
   localparam logic [1:0] OP_BC = 2'd3;

   localparam logic [QW-1:0]        UNIT_Q = QW'(1 << NF);
   localparam logic signed [NW-1:0] UNIT_N = NW'(1 << NF);
   localparam logic signed [CW-1:0] MAX_C  = CW'((1 << (CW - 1)) - 1);
   localparam logic signed [CW-1:0] MIN_C  = -MAX_C - CW'(1);

   typedef struct packed {
      logic [1:0]           operation;
      logic signed [CW-1:0] a_px;
      logic signed [CW-1:0] a_py;
      logic signed [CW-1:0] a_qx;
      logic signed [CW-1:0] a_qy;
      logic [RW-1:0]        a_radius;
      logic signed [CW-1:0] b_px;
      logic signed [CW-1:0] b_py;
      logic signed [CW-1:0] b_qx;
      logic signed [CW-1:0] b_qy;
      logic [RW-1:0]        b_radius;
   } req_type;

   typedef struct packed {
      logic                 hit;
      logic signed [NW-1:0] normal_x;
      logic signed [NW-1:0] normal_y;
      logic [MW-1:0]        depth;
      logic signed [CW-1:0] contact_x;
      logic signed [CW-1:0] contact_y;
   } rsp_type;

   typedef struct packed {
      logic                 is_box;
      logic                 box_hit;
      logic                 negate;
      logic                 miss;
      logic                 dx_neg;
      logic                 dy_neg;
      logic [MW-1:0]        dx_mag;
      logic [MW-1:0]        dy_mag;
      logic [MW-1:0]        thr;
      logic [RW-1:0]        sub;
      logic signed [CW-1:0] ox;
      logic signed [CW-1:0] oy;
      logic signed [NW-1:0] bnx;
      logic signed [NW-1:0] bny;
      logic [MW-1:0]        bd;
      logic [SQW-1:0]       m;
   } carry_type;

   typedef struct packed {
      logic                  hit;
      logic signed [NW-1:0]  nx;
      logic signed [NW-1:0]  ny;
      logic [MW-1:0]         depth;
      logic signed [DSW-1:0] span;
      logic signed [CW-1:0]  ox;
      logic signed [CW-1:0]  oy;
   } post_type;

   function automatic logic signed [MW-1:0] sext1(logic signed [CW-1:0] x);
      return {x[CW-1], x};
   endfunction

   function automatic logic signed [CW-1:0] place(logic signed [CW-1:0] o,
                                                  logic signed [PW-1:0] p);
      logic [PW-1:0]        mag;
      logic [PW-1:0]        rsum;
      logic [PW-NF-1:0]     u;
      logic signed [TW-1:0] s;
      logic signed [TW-1:0] t;
      mag  = p[PW-1] ? PW'(-p) : PW'(p);
      rsum = mag + (PW'(1) << (NF - 1));
      u    = rsum[PW-1:NF];
      s    = p[PW-1] ? -signed'({2'b00, u}) : signed'({2'b00, u});
      t    = s + TW'(o);
      if (t > TW'(MAX_C)) begin
         return MAX_C;
      end else if (t < TW'(MIN_C)) begin
         return MIN_C;
      end
      return t[CW-1:0];
   endfunction

endpackage

@@ sv/narrow_phase_collision_manifold_unit.sv @@
// Top level of the narrow-phase collision manifold unit: a fully pipelined datapath.
`timescale 1ns / 1ps

// Usage: one shape pair enters as a beat on the req_ channel (req_valid, req_stall,
// req_payload) and exactly one manifold leaves as a beat on the rsp_ channel
// (rsp_valid, rsp_stall, rsp_payload), in the order the pairs were taken.
// The datapath is a 47-register pipeline: input decode, squaring, sum and compare,
// one stage per bit of the 25-bit square root, numerator setup, one stage per bit
// of the 15-bit normal divide (both axes side by side), normal select, product,
// and round with saturation into the output register.
// The unit takes one beat every cycle while the output is not stalled; the square root
// and divide stages set the latency, while the throughput is one pair per clock.
// When the receiver stalls a valid result, the whole pipeline holds and req_stall
// rises in the same cycle; nothing is dropped or repeated, and bubbles move on
// freely whenever the output register is empty or being taken.
// A synchronous reset empties the pipeline: all valid flags clear, rsp_valid is
// low and req_stall is low from the first cycle after reset.
module narrow_phase_collision_manifold_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ncm_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ncm_pkg::rsp_type rsp_payload
);
   import ncm_pkg::*;

   logic en;

   logic      s1_v_ff;
   carry_type s1_c_ff, s1_c_in;
   logic      s2_v_ff;
   carry_type s2_c_ff;
   logic [L2W-1:0] s2_sqx_ff, s2_sqy_ff, s2_sqt_ff;
   carry_type sq_c0_in, dv_c0_in;

   logic           sq_v_ff    [SQW+1];
   carry_type      sq_c_ff    [SQW+1];
   logic [L2W-1:0] sq_rem_ff  [SQW+1];
   logic [SQW-1:0] sq_root_ff [SQW+1];

   logic            dv_v_ff  [QW+1];
   carry_type       dv_c_ff  [QW+1];
   logic [NUMW-1:0] dv_rx_ff [QW+1];
   logic [NUMW-1:0] dv_ry_ff [QW+1];
   logic [QW-1:0]   dv_qx_ff [QW+1];
   logic [QW-1:0]   dv_qy_ff [QW+1];

   logic     sn_v_ff;
   post_type sn_p_ff, sn_p_in;
   logic     sm_v_ff;
   post_type sm_p_ff;
   logic signed [PW-1:0] sm_px_ff, sm_py_ff;

   logic    rsp_valid_ff;
   rsp_type rsp_ff, rsp_in;

   assign en          = !(rsp_valid_ff && rsp_stall);
   assign req_stall   = !en;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Input decode.
   logic signed [CW-1:0] cx, cy, bpx, bpy, bqx, bqy, kx, ky;
   logic signed [CW-1:0] minqx, maxpx, minqy, maxpy;
   logic signed [MW-1:0] dx_s, dy_s, ovx, ovy, dsel;
   logic [RW-1:0]        crad;
   logic                 sep;

   always_comb begin
      if (req_payload.operation == OP_BC) begin
         cx = req_payload.b_px;  cy = req_payload.b_py;  crad = req_payload.b_radius;
         bpx = req_payload.a_px; bpy = req_payload.a_py;
         bqx = req_payload.a_qx; bqy = req_payload.a_qy;
      end else begin
         cx = req_payload.a_px;  cy = req_payload.a_py;  crad = req_payload.a_radius;
         bpx = req_payload.b_px; bpy = req_payload.b_py;
         bqx = req_payload.b_qx; bqy = req_payload.b_qy;
      end
      kx = (cx < bpx) ? bpx : ((cx > bqx) ? bqx : cx);
      ky = (cy < bpy) ? bpy : ((cy > bqy) ? bqy : cy);

      minqx = (req_payload.a_qx < req_payload.b_qx) ? req_payload.a_qx : req_payload.b_qx;
      maxpx = (req_payload.a_px > req_payload.b_px) ? req_payload.a_px : req_payload.b_px;
      minqy = (req_payload.a_qy < req_payload.b_qy) ? req_payload.a_qy : req_payload.b_qy;
      maxpy = (req_payload.a_py > req_payload.b_py) ? req_payload.a_py : req_payload.b_py;
      ovx   = sext1(minqx) - sext1(maxpx);
      ovy   = sext1(minqy) - sext1(maxpy);
      dsel  = (ovx < ovy) ? ovx : ovy;
      sep   = (req_payload.a_qx < req_payload.b_px) || (req_payload.a_px > req_payload.b_qx) ||
              (req_payload.a_qy < req_payload.b_py) || (req_payload.a_py > req_payload.b_qy);

      s1_c_in = '0;
      case (req_payload.operation)
         OP_CC: begin
            dx_s = sext1(req_payload.b_px) - sext1(req_payload.a_px);
            dy_s = sext1(req_payload.b_py) - sext1(req_payload.a_py);
            s1_c_in.thr = MW'(req_payload.a_radius) + MW'(req_payload.b_radius);
            s1_c_in.sub = req_payload.b_radius;
            s1_c_in.ox  = req_payload.a_px;
            s1_c_in.oy  = req_payload.a_py;
         end
         OP_BB: begin
            dx_s = '0;
            dy_s = '0;
            s1_c_in.is_box = 1'b1;
            s1_c_in.ox     = req_payload.a_px;
            s1_c_in.oy     = req_payload.a_py;
         end
         default: begin
            dx_s = sext1(kx) - sext1(cx);
            dy_s = sext1(ky) - sext1(cy);
            s1_c_in.thr    = MW'(crad);
            s1_c_in.ox     = cx;
            s1_c_in.oy     = cy;
            s1_c_in.negate = (req_payload.operation == OP_BC);
         end
      endcase
      s1_c_in.dx_neg  = dx_s[MW-1];
      s1_c_in.dy_neg  = dy_s[MW-1];
      s1_c_in.dx_mag  = dx_s[MW-1] ? MW'(-dx_s) : MW'(dx_s);
      s1_c_in.dy_mag  = dy_s[MW-1] ? MW'(-dy_s) : MW'(dy_s);
      s1_c_in.box_hit = !sep;
      s1_c_in.bd      = dsel[MW-1] ? '0 : MW'(dsel);
      if (ovx < ovy) begin
         s1_c_in.bnx = (req_payload.a_px > req_payload.b_px) ? -UNIT_N : UNIT_N;
      end else begin
         s1_c_in.bny = (req_payload.a_py > req_payload.b_py) ? -UNIT_N : UNIT_N;
      end
   end

   always_comb begin
      sq_c0_in      = s2_c_ff;
      sq_c0_in.miss = (s2_sqx_ff + s2_sqy_ff) > s2_sqt_ff;
      dv_c0_in      = sq_c_ff[SQW];
      dv_c0_in.m    = sq_root_ff[SQW];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         sq_v_ff[0] <= 1'b0;
      end else if (en) begin
         s1_v_ff    <= req_valid;
         s2_v_ff    <= s1_v_ff;
         sq_v_ff[0] <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_c_ff   <= s1_c_in;
         s2_c_ff   <= s1_c_ff;
         s2_sqx_ff <= s1_c_ff.dx_mag * s1_c_ff.dx_mag;
         s2_sqy_ff <= s1_c_ff.dy_mag * s1_c_ff.dy_mag;
         s2_sqt_ff <= s1_c_ff.thr * s1_c_ff.thr;
         sq_rem_ff[0]  <= s2_sqx_ff + s2_sqy_ff;
         sq_root_ff[0] <= '0;
         sq_c_ff[0]    <= sq_c0_in;
      end
   end

   // Square root, one result bit per stage.
   for (genvar j = 0; j < SQW; j++) begin : g_sqrt
      localparam int K = SQW - 1 - j;
      logic [L2W-1:0] trial;
      logic [L2W-1:0] rem_in;
      logic [SQW-1:0] root_in;
      always_comb begin
         trial = (L2W'(sq_root_ff[j]) << (K + 1)) + (L2W'(1) << (2 * K));
         if (sq_rem_ff[j] >= trial) begin
            rem_in  = sq_rem_ff[j] - trial;
            root_in = sq_root_ff[j] | (SQW'(1) << K);
         end else begin
            rem_in  = sq_rem_ff[j];
            root_in = sq_root_ff[j];
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            sq_v_ff[j+1] <= 1'b0;
         end else if (en) begin
            sq_v_ff[j+1] <= sq_v_ff[j];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            sq_rem_ff[j+1]  <= rem_in;
            sq_root_ff[j+1] <= root_in;
            sq_c_ff[j+1]    <= sq_c_ff[j];
         end
      end
   end

   // Numerator setup for the normal divide.
   always_ff @(posedge clock) begin
      if (reset) begin
         dv_v_ff[0] <= 1'b0;
      end else if (en) begin
         dv_v_ff[0] <= sq_v_ff[SQW];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dv_c_ff[0]   <= dv_c0_in;
         dv_rx_ff[0]  <= (NUMW'(sq_c_ff[SQW].dx_mag) << NF) + NUMW'(sq_root_ff[SQW] >> 1);
         dv_ry_ff[0]  <= (NUMW'(sq_c_ff[SQW].dy_mag) << NF) + NUMW'(sq_root_ff[SQW] >> 1);
         dv_qx_ff[0]  <= '0;
         dv_qy_ff[0]  <= '0;
      end
   end

   // Restoring divide, one quotient bit per stage for both axes.
   for (genvar j = 0; j < QW; j++) begin : g_div
      localparam int I = QW - 1 - j;
      logic [NUMW-1:0] dsub;
      logic [NUMW-1:0] rx_in, ry_in;
      logic [QW-1:0]   qx_in, qy_in;
      always_comb begin
         dsub  = NUMW'(dv_c_ff[j].m) << I;
         rx_in = dv_rx_ff[j];
         qx_in = dv_qx_ff[j];
         ry_in = dv_ry_ff[j];
         qy_in = dv_qy_ff[j];
         if (dv_rx_ff[j] >= dsub) begin
            rx_in = dv_rx_ff[j] - dsub;
            qx_in = dv_qx_ff[j] | (QW'(1) << I);
         end
         if (dv_ry_ff[j] >= dsub) begin
            ry_in = dv_ry_ff[j] - dsub;
            qy_in = dv_qy_ff[j] | (QW'(1) << I);
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_v_ff[j+1] <= 1'b0;
         end else if (en) begin
            dv_v_ff[j+1] <= dv_v_ff[j];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            dv_c_ff[j+1]  <= dv_c_ff[j];
            dv_rx_ff[j+1] <= rx_in;
            dv_ry_ff[j+1] <= ry_in;
            dv_qx_ff[j+1] <= qx_in;
            dv_qy_ff[j+1] <= qy_in;
         end
      end
   end

   // Normal, depth and distance selection.
   carry_type            fc;
   logic [QW-1:0]        qcx, qcy;
   logic signed [NW-1:0] nx_c, ny_c;

   // For a box-circle pair the normal is flipped, so the distance is flipped as well
   // to keep the contact point on the circle's own normal.
   always_comb begin
      fc   = dv_c_ff[QW];
      qcx  = (dv_qx_ff[QW] > UNIT_Q) ? UNIT_Q : dv_qx_ff[QW];
      qcy  = (dv_qy_ff[QW] > UNIT_Q) ? UNIT_Q : dv_qy_ff[QW];
      nx_c = fc.dx_neg ? -signed'(NW'(qcx)) : signed'(NW'(qcx));
      ny_c = fc.dy_neg ? -signed'(NW'(qcy)) : signed'(NW'(qcy));
      if (fc.negate) begin
         nx_c = -nx_c;
         ny_c = -ny_c;
      end
      if (fc.m == '0) begin
         nx_c = '0;
         ny_c = '0;
      end
      sn_p_in.ox = fc.ox;
      sn_p_in.oy = fc.oy;
      if (fc.is_box) begin
         sn_p_in.hit   = fc.box_hit;
         sn_p_in.nx    = fc.bnx;
         sn_p_in.ny    = fc.bny;
         sn_p_in.depth = fc.bd;
         sn_p_in.span  = signed'(DSW'(fc.bd));
      end else begin
         sn_p_in.hit   = !fc.miss;
         sn_p_in.nx    = nx_c;
         sn_p_in.ny    = ny_c;
         sn_p_in.depth = fc.thr - MW'(fc.m);
         sn_p_in.span  = fc.negate ? signed'(DSW'(fc.sub)) - signed'(DSW'(fc.m))
                                   : signed'(DSW'(fc.m)) - signed'(DSW'(fc.sub));
      end
   end

   always_comb begin
      rsp_in = '0;
      if (sm_p_ff.hit) begin
         rsp_in.hit       = 1'b1;
         rsp_in.normal_x  = sm_p_ff.nx;
         rsp_in.normal_y  = sm_p_ff.ny;
         rsp_in.depth     = sm_p_ff.depth;
         rsp_in.contact_x = place(sm_p_ff.ox, sm_px_ff);
         rsp_in.contact_y = place(sm_p_ff.oy, sm_py_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sn_v_ff      <= 1'b0;
         sm_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         sn_v_ff      <= dv_v_ff[QW];
         sm_v_ff      <= sn_v_ff;
         rsp_valid_ff <= sm_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sn_p_ff  <= sn_p_in;
         sm_p_ff  <= sn_p_ff;
         sm_px_ff <= PW'(sn_p_ff.nx) * PW'(sn_p_ff.span);
         sm_py_ff <= PW'(sn_p_ff.ny) * PW'(sn_p_ff.span);
         rsp_ff   <= rsp_in;
      end
   end

   a_miss_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.hit |-> rsp_ff.normal_x == '0 && rsp_ff.normal_y == '0 &&
      rsp_ff.depth == '0 && rsp_ff.contact_x == '0 && rsp_ff.contact_y == '0)
      else $error("Missed pair carries a nonzero field.");

   a_normal_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.hit |-> rsp_ff.normal_x <= UNIT_N && rsp_ff.normal_x >= -UNIT_N &&
      rsp_ff.normal_y <= UNIT_N && rsp_ff.normal_y >= -UNIT_N)
      else $error("Normal component exceeds unit length.");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid_ff && rsp_stall)
      else $error("Input stalled while the output register can move.");

   a_pipe_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(s1_v_ff) && $stable(sq_v_ff[SQW]) && $stable(dv_v_ff[QW]))
      else $error("Pipeline moved during an output stall.");

endmodule

@@ tb/testbench.sv @@
// Testbench for the narrow-phase collision manifold unit: directed table plus random pairs.
`timescale 1ns / 1ps

module testbench;
   import ncm_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int LATENCY = 46;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;

   rsp_type manifold_queue[$];
   int      mismatch_count = 0;
   int      idle_cycles = 0;
   int      send_idle_pct = 0;
   int      recv_stall_pct = 0;

   narrow_phase_collision_manifold_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint abs_val(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic longint unit_comp(longint d, longint m);
      longint q;
      if (m == 0) return 0;
      q = ((abs_val(d) << NF) + m / 2) / m;
      if (q > (64'sd1 << NF)) q = 64'sd1 << NF;
      return d < 0 ? -q : q;
   endfunction

   function automatic longint scaled(longint n, longint span);
      longint p;
      longint u;
      p = n * span;
      u = (abs_val(p) + (64'sd1 << (NF - 1))) >>> NF;
      return p < 0 ? -u : u;
   endfunction

   function automatic longint clamp_coord(longint v);
      longint hi;
      hi = (64'sd1 <<< (CW - 1)) - 1;
      return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
   endfunction

   function automatic rsp_type predict_manifold(req_type q);
      rsp_type r;
      longint  ax, ay, aqx, aqy, bx, by, bqx, bqy, ra, rb;
      longint  cx, cy, rad, px, py, qx, qy, kx, ky;
      longint  dx, dy, m, l2, nx, ny, dep, ox, oy, d, ex, ey;
      r = '0;
      ax = q.a_px; ay = q.a_py; aqx = q.a_qx; aqy = q.a_qy;
      bx = q.b_px; by = q.b_py; bqx = q.b_qx; bqy = q.b_qy;
      ra = longint'(q.a_radius); rb = longint'(q.b_radius);
      if (q.operation == OP_CC) begin
         dx = bx - ax; dy = by - ay;
         l2 = dx * dx + dy * dy;
         if (l2 <= (ra + rb) * (ra + rb)) begin
            m = int_sqrt(l2);
            dep = ra + rb - m;
            nx = unit_comp(dx, m); ny = unit_comp(dy, m);
            r.hit = 1'b1; r.normal_x = NW'(nx); r.normal_y = NW'(ny); r.depth = MW'(dep);
            r.contact_x = CW'(clamp_coord(ax + scaled(nx, ra - dep)));
            r.contact_y = CW'(clamp_coord(ay + scaled(ny, ra - dep)));
         end
      end else if (q.operation == OP_BB) begin
         if (!(aqx < bx || ax > bqx || aqy < by || ay > bqy)) begin
            ex = (aqx < bqx ? aqx : bqx) - (ax > bx ? ax : bx);
            ey = (aqy < bqy ? aqy : bqy) - (ay > by ? ay : by);
            d = ex < ey ? ex : ey;
            if (d < 0) d = 0;
            nx = 0; ny = 0;
            if (ex < ey) nx = ax > bx ? -(64'sd1 << NF) : (64'sd1 << NF);
            else ny = ay > by ? -(64'sd1 << NF) : (64'sd1 << NF);
            r.hit = 1'b1; r.normal_x = NW'(nx); r.normal_y = NW'(ny); r.depth = MW'(d);
            r.contact_x = CW'(clamp_coord(ax + scaled(nx, d)));
            r.contact_y = CW'(clamp_coord(ay + scaled(ny, d)));
         end
      end else begin
         if (q.operation == OP_CB) begin
            cx = ax; cy = ay; rad = ra; px = bx; py = by; qx = bqx; qy = bqy;
         end else begin
            cx = bx; cy = by; rad = rb; px = ax; py = ay; qx = aqx; qy = aqy;
         end
         kx = cx < px ? px : (cx > qx ? qx : cx);
         ky = cy < py ? py : (cy > qy ? qy : cy);
         dx = kx - cx; dy = ky - cy;
         l2 = dx * dx + dy * dy;
         if (l2 <= rad * rad) begin
            m = int_sqrt(l2);
            nx = unit_comp(dx, m); ny = unit_comp(dy, m);
            r.hit = 1'b1; r.depth = MW'(rad - m);
            r.contact_x = CW'(clamp_coord(cx + scaled(nx, m)));
            r.contact_y = CW'(clamp_coord(cy + scaled(ny, m)));
            if (q.operation == OP_BC) begin
               nx = -nx; ny = -ny;
            end
            r.normal_x = NW'(nx); r.normal_y = NW'(ny);
         end
      end
      return r;
   endfunction

   task automatic send_pair(req_type q);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= q;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      manifold_queue.push_back(predict_manifold(q));
   endtask

   function automatic logic signed [CW-1:0] rand_coord(int mode);
      case (mode)
         0: return CW'($urandom);
         1: return CW'($signed($urandom_range(8192)) - 4096);
         default: return CW'($signed($urandom_range(200000)) - 100000);
      endcase
   endfunction

   function automatic req_type rand_pair();
      req_type q;
      int      mode;
      logic signed [CW-1:0] t;
      mode = $urandom_range(2);
      q.operation = 2'($urandom_range(3));
      q.a_px = rand_coord(mode); q.a_py = rand_coord(mode);
      q.b_px = rand_coord(mode); q.b_py = rand_coord(mode);
      q.a_qx = q.a_px + CW'($urandom_range(6000));
      q.a_qy = q.a_py + CW'($urandom_range(6000));
      q.b_qx = q.b_px + CW'($urandom_range(6000));
      q.b_qy = q.b_py + CW'($urandom_range(6000));
      if ($urandom_range(9) == 0) q.a_qx = rand_coord(mode);
      if ($urandom_range(9) == 0) q.b_qy = rand_coord(mode);
      q.a_radius = mode == 0 ? RW'($urandom) : RW'($urandom_range(6000));
      q.b_radius = mode == 0 ? RW'($urandom) : RW'($urandom_range(6000));
      if ($urandom_range(19) == 0) begin
         t = rand_coord(0); q.b_px = t; q.a_px = t; q.b_py = q.a_py;
      end
      return q;
   endfunction

   function automatic req_type make_pair(logic [1:0] op, int apx, int apy, int aqx, int aqy,
                                         int ar, int bpx, int bpy, int bqx, int bqy, int br);
      req_type q;
      q.operation = op;
      q.a_px = CW'(apx); q.a_py = CW'(apy); q.a_qx = CW'(aqx); q.a_qy = CW'(aqy);
      q.a_radius = RW'(ar);
      q.b_px = CW'(bpx); q.b_py = CW'(bpy); q.b_qx = CW'(bqx); q.b_qy = CW'(bqy);
      q.b_radius = RW'(br);
      return q;
   endfunction

   localparam int CMAX = 8388607;
   localparam int CMIN = -8388608;
   localparam int RMAX = 8388607;

   typedef struct {
      req_type q;
      logic    known;
      rsp_type r;
   } table_row_type;

   table_row_type stimulus_table[$];

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
         if (rsp_valid && !rsp_stall) begin
            if (manifold_queue.size() == 0) begin
               mismatch_count = mismatch_count + 1;
               if (mismatch_count <= 10) $display("Unexpected beat: %p", rsp_payload);
            end else begin
               if (rsp_payload !== manifold_queue[0]) begin
                  mismatch_count = mismatch_count + 1;
                  if (mismatch_count <= 10)
                     $display("Mismatch: expected %p, actual %p", manifold_queue[0], rsp_payload);
               end
               void'(manifold_queue.pop_front());
            end
         end
         if (recv_stall_pct > 0) rsp_stall <= $urandom_range(99) < recv_stall_pct;
         else rsp_stall <= 1'b0;
      end
   end

   initial begin
      table_row_type row;
      rsp_type       miss;
      int            phase;
      miss = '0;
      row.known = 1'b1; row.r = miss;
      row.q = make_pair(OP_CC, 0, 0, 0, 0, 256, 1024, 0, 0, 0, 256);
      stimulus_table.push_back(row);
      row.q = make_pair(OP_CC, CMIN, CMIN, 0, 0, 0, CMAX, CMAX, 0, 0, 0);
      stimulus_table.push_back(row);
      row.q = make_pair(OP_BB, 0, 0, 100, 100, 0, 200, 0, 300, 100, 0);
      stimulus_table.push_back(row);
      row.q = make_pair(OP_CB, 0, 0, 0, 0, 10, 100, 100, 200, 200, 0);
      stimulus_table.push_back(row);
      row.q = make_pair(OP_BC, 100, 100, 200, 200, 0, 0, 0, 0, 0, 10);
      stimulus_table.push_back(row);
      row.r = '0; row.r.hit = 1'b1; row.r.depth = '0;
      row.r.contact_x = CW'(500); row.r.contact_y = CW'(-7);
      row.q = make_pair(OP_CC, 500, -7, 0, 0, 0, 500, -7, 0, 0, 0);
      stimulus_table.push_back(row);
      row.r = '0; row.r.hit = 1'b1; row.r.normal_x = UNIT_N; row.r.depth = MW'(512);
      row.r.contact_x = CW'(512);
      row.q = make_pair(OP_CC, 0, 0, 0, 0, 1024, 1024, 0, 0, 0, 512);
      stimulus_table.push_back(row);
      row.known = 1'b0;
      row.q = make_pair(OP_CC, 0, 0, 0, 0, RMAX, CMAX, CMAX, 0, 0, RMAX);
      stimulus_table.push_back(row);
      row.q = make_pair(OP_CC, CMIN, CMAX, 0, 0, RMAX, CMAX, CMIN, 0, 0, RMAX);
      stimulus_table.push_back(row);
      row.q = make_pair(OP_CC, 0, 0, 0, 0, 300, -200, 150, 0, 0, 300);
      stimulus_table.push_back(row);
      row.q = make_pair(OP_BB, 0, 0, 1000, 1000, 0, 900, 100, 2000, 800, 0);
      stimulus_table.push_back(row);
      row.q = make_pair(OP_BB, 900, 0, 2000, 1000, 0, 0, 100, 1000, 900, 0);
      stimulus_table.push_back(row);
      row.q = make_pair(OP_BB, 0, 500, 1000, 1000, 0, 0, 0, 1000, 600, 0);
      stimulus_table.push_back(row);
      row.q = make_pair(OP_BB, CMIN, CMIN, CMAX, CMAX, 0, CMIN, CMIN, CMAX, CMAX, 0);
      stimulus_table.push_back(row);
      row.q = make_pair(OP_BB, 500, 500, 100, 100, 0, 0, 0, 1000, 1000, 0);
      stimulus_table.push_back(row);
      row.q = make_pair(OP_CB, 50, 50, 0, 0, 100, 0, 0, 100, 100, 0);
      stimulus_table.push_back(row);
      row.q = make_pair(OP_CB, -30, 40, 0, 0, 100, 0, 0, 100, 100, 0);
      stimulus_table.push_back(row);
      row.q = make_pair(OP_CB, CMAX, CMAX, 0, 0, RMAX, CMIN, CMIN, CMIN, CMIN, 0);
      stimulus_table.push_back(row);
      row.q = make_pair(OP_BC, 0, 0, 100, 100, 0, 150, 120, 0, 0, 80);
      stimulus_table.push_back(row);
      row.q = make_pair(OP_BC, CMIN, CMIN, CMAX, CMAX, 0, CMAX, CMIN, 0, 0, RMAX);
      stimulus_table.push_back(row);

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (stimulus_table[i]) begin
         send_pair(stimulus_table[i].q);
         if (stimulus_table[i].known && manifold_queue[$] !== stimulus_table[i].r) begin
            mismatch_count = mismatch_count + 1;
            $display("Table row %0d: expected %p, predicted %p", i, stimulus_table[i].r,
                     manifold_queue[$]);
         end
      end

      for (phase = 0; phase < 5; phase++) begin
         case (phase)
            1: begin send_idle_pct = 80; recv_stall_pct = 0; end
            2: begin send_idle_pct = 0; recv_stall_pct = 80; end
            3: begin send_idle_pct = 26; recv_stall_pct = 26; end
            default: begin send_idle_pct = 0; recv_stall_pct = 0; end
         endcase
         repeat (100) send_pair(rand_pair());
         if (phase == 2) begin
            req_valid <= 1'b0;
            while (manifold_queue.size() != 0) @(posedge clock);
         end
      end

      req_valid <= 1'b0;
      while (manifold_queue.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule
